@@ hdl/cld_pkg.sv @@
// Shared types and constants for the console line discipline.
// Depends on nothing; imported by the top level and its checker.
package cld_pkg;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam int unsigned LEN_W   = 6;
  localparam int unsigned TDATA_W = 16;

  typedef enum logic [1:0] {
    FUNC_RX       = 2'd0,
    FUNC_WRITE    = 2'd1,
    FUNC_TX_READY = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_TX        = 2'd0,
    KIND_LINE_BYTE = 2'd1,
    KIND_LINE_DONE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_TX_RD,
    ST_TX_OUT,
    ST_LINE,
    ST_LINE_RD,
    ST_LINE_OUT,
    ST_DONE_OUT
  } state_e;

endpackage

@@ hdl/console_line_discipline.sv @@
// Console line discipline: echo, line assembly and transmit queue.
// Depends on cld_pkg.
//
// One item is handled at a time. An ignored item, a received byte while disabled
// or a transmitter-ready item that idles the transmitter is done on transfer. A
// transmitter-ready item that pops a byte reads the transmit queue, then sends the
// byte. A write byte is pushed into the queue; when it starts transmission, the
// head byte is then read and sent. A received byte is pushed the same way as its
// echo, may start the echo, and then goes to the line stage, which stores it in
// the line memory while there is room or, for a line end, reads and sends each
// stored line byte in turn, the memory being read one entry per pass with a
// registered read, followed by the line-complete result. Both stores are
// synchronous single-port memories; stalls on the result side hold the block in
// its output states.
module console_line_discipline #(
  parameter int unsigned TX_DEPTH   = 32,
  parameter int unsigned LINE_DEPTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_data_i,     // console_enabled
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i, // [7:0] data_byte
  input  logic [1:0]                   s_axis_tuser_i, // [1:0] func
  input  logic                         s_axis_tlast_i, // write_last
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [cld_pkg::TDATA_W-1:0]  m_axis_tdata_o, // [7:0] out_byte, [13:8] line_length
  output logic [1:0]                   m_axis_tuser_o, // [1:0] kind
  output logic                         m_axis_tlast_o  // last
);
  import cld_pkg::*;

  localparam int unsigned TX_AW = $clog2(TX_DEPTH);
  localparam int unsigned TX_CW = $clog2(TX_DEPTH + 1);
  localparam int unsigned TX_SW = TX_CW + 1;
  localparam int unsigned LN_AW = $clog2(LINE_DEPTH);
  localparam int unsigned LN_CW = $clog2(LINE_DEPTH + 1);

  state_e            state_q, state_d;
  logic              en_q;
  logic              active_q;
  logic [TX_AW-1:0]  head_q;
  logic [TX_CW-1:0]  tx_cnt_q;
  logic [LN_CW-1:0]  ln_cnt_q;
  logic [LN_CW-1:0]  idx_q;
  logic [LN_CW-1:0]  idx_nxt;
  logic [1:0]        func_q;
  logic [7:0]        byte_q;
  logic              wlast_q;

  logic [7:0]        tx_mem [TX_DEPTH];
  logic [7:0]        ln_mem [LINE_DEPTH];
  logic [7:0]        tx_rd_q;
  logic [7:0]        ln_rd_q;

  logic              out_valid_q;
  logic [TDATA_W-1:0] out_data_q;
  logic [1:0]        out_kind_q;
  logic              out_last_q;

  logic              accept;
  logic [7:0]        in_byte;
  logic              slot_free;
  logic              tx_full;
  logic              push_en;
  logic [7:0]        push_byte;
  logic              pop_en;
  logic              set_active;
  logic              clr_active;
  logic              start_tx;
  logic              line_wr;
  logic              line_rd;
  logic              line_clr;
  logic              idx_clr;
  logic              idx_inc;
  logic              emit;
  kind_e             emit_kind;
  logic [7:0]        emit_byte;
  logic [LEN_W-1:0]  emit_len;
  logic              emit_last;
  logic [TX_SW-1:0]  tail_sum;
  logic [TX_AW-1:0]  tail;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_byte = (s_axis_tuser_i == FUNC_RX && s_axis_tdata_i == CH_CR) ? CH_LF
                                                                           : s_axis_tdata_i;
  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign tx_full   = (tx_cnt_q == TX_CW'(TX_DEPTH));
  assign idx_nxt   = idx_q + LN_CW'(1);
  assign start_tx  = (func_q == FUNC_RX || wlast_q) && !active_q
                     && (!tx_full || tx_cnt_q != '0);

  assign tail_sum = TX_SW'(head_q) + TX_SW'(tx_cnt_q);
  assign tail     = (tail_sum >= TX_SW'(TX_DEPTH)) ? TX_AW'(tail_sum - TX_SW'(TX_DEPTH))
                                                   : TX_AW'(tail_sum);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority if ((s_axis_tuser_i == FUNC_RX && en_q) || s_axis_tuser_i == FUNC_WRITE) begin
            state_d = ST_PUSH;
          end else if (s_axis_tuser_i == FUNC_TX_READY && en_q && tx_cnt_q != '0) begin
            state_d = ST_TX_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_PUSH: begin
        priority if (start_tx)         state_d = ST_TX_RD;
        else if (func_q == FUNC_RX)    state_d = ST_LINE;
        else                           state_d = ST_IDLE;
      end
      ST_TX_RD:  state_d = ST_TX_OUT;
      ST_TX_OUT: begin
        if (slot_free) state_d = (func_q == FUNC_RX) ? ST_LINE : ST_IDLE;
      end
      ST_LINE: begin
        priority if (byte_q != CH_LF) state_d = ST_IDLE;
        else if (ln_cnt_q == '0)      state_d = ST_DONE_OUT;
        else                          state_d = ST_LINE_RD;
      end
      ST_LINE_RD:  state_d = ST_LINE_OUT;
      ST_LINE_OUT: begin
        if (slot_free) state_d = (idx_nxt == ln_cnt_q) ? ST_DONE_OUT : ST_LINE_RD;
      end
      ST_DONE_OUT: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    push_en    = 1'b0;
    push_byte  = byte_q;
    pop_en     = 1'b0;
    set_active = 1'b0;
    clr_active = 1'b0;
    line_wr    = 1'b0;
    line_rd    = 1'b0;
    line_clr   = 1'b0;
    idx_clr    = 1'b0;
    idx_inc    = 1'b0;
    emit       = 1'b0;
    emit_kind  = KIND_TX;
    emit_byte  = tx_rd_q;
    emit_len   = '0;
    emit_last  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (((s_axis_tuser_i == FUNC_RX && en_q) || s_axis_tuser_i == FUNC_WRITE)
              && in_byte == CH_LF) begin
            push_en   = !tx_full;
            push_byte = CH_CR;
          end
          if (s_axis_tuser_i == FUNC_TX_READY && !(en_q && tx_cnt_q != '0)) begin
            clr_active = 1'b1;
          end
        end
      end
      ST_PUSH: begin
        push_en    = !tx_full;
        set_active = start_tx;
      end
      ST_TX_RD: pop_en = 1'b1;
      ST_TX_OUT: begin
        emit      = slot_free;
        emit_last = !(func_q == FUNC_RX && byte_q == CH_LF);
      end
      ST_LINE: begin
        line_wr = (byte_q != CH_LF) && (ln_cnt_q != LN_CW'(LINE_DEPTH));
        idx_clr = 1'b1;
      end
      ST_LINE_RD: line_rd = 1'b1;
      ST_LINE_OUT: begin
        emit      = slot_free;
        idx_inc   = slot_free;
        emit_kind = KIND_LINE_BYTE;
        emit_byte = ln_rd_q;
        emit_last = 1'b0;
      end
      ST_DONE_OUT: begin
        emit      = slot_free;
        line_clr  = slot_free;
        emit_kind = KIND_LINE_DONE;
        emit_byte = '0;
        emit_len  = LEN_W'(ln_cnt_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      en_q        <= 1'b0;
      active_q    <= 1'b0;
      head_q      <= '0;
      tx_cnt_q    <= '0;
      ln_cnt_q    <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) en_q <= cfg_data_i;
      if (set_active) active_q <= 1'b1;
      else if (clr_active) active_q <= 1'b0;
      if (push_en) tx_cnt_q <= tx_cnt_q + TX_CW'(1);
      if (pop_en) begin
        tx_cnt_q <= tx_cnt_q - TX_CW'(1);
        head_q   <= (head_q == TX_AW'(TX_DEPTH - 1)) ? '0 : head_q + TX_AW'(1);
      end
      if (line_wr) ln_cnt_q <= ln_cnt_q + LN_CW'(1);
      else if (line_clr) ln_cnt_q <= '0;
      if (idx_clr) idx_q <= '0;
      else if (idx_inc) idx_q <= idx_nxt;
      if (emit) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= s_axis_tuser_i;
      byte_q  <= in_byte;
      wlast_q <= s_axis_tlast_i;
    end
    if (emit) begin
      out_data_q <= {(TDATA_W - LEN_W - 8)'(0), emit_len, emit_byte};
      out_kind_q <= emit_kind;
      out_last_q <= emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) tx_mem[tail] <= push_byte;
    if (pop_en) tx_rd_q <= tx_mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (line_wr) ln_mem[ln_cnt_q[LN_AW-1:0]] <= byte_q;
    if (line_rd) ln_rd_q <= ln_mem[idx_q[LN_AW-1:0]];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ hdl/cld_checker.sv @@
// Port-level checks for console_line_discipline, attached by bind.
// Depends on cld_pkg.
module cld_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic                        cfg_data_i,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic [7:0]                  s_axis_tdata_i,
  input logic [1:0]                  s_axis_tuser_i,
  input logic                        s_axis_tlast_i,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [cld_pkg::TDATA_W-1:0] m_axis_tdata_o,
  input logic [1:0]                  m_axis_tuser_o,
  input logic                        m_axis_tlast_o
);
  import cld_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  a_len_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != KIND_LINE_DONE |-> m_axis_tdata_o[13:8] == '0)
    else $error("line length on a non-complete result");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_LINE_DONE |->
      m_axis_tlast_o && m_axis_tdata_o[7:0] == '0)
    else $error("line complete without last or with data");

  a_line_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_LINE_BYTE |-> !m_axis_tlast_o)
    else $error("line byte marked last");

endmodule

bind console_line_discipline cld_checker u_cld_checker (.*);
